// ----- rtl/mtcp_pkg.sv -----
package mtcp_pkg;

	localparam int unsigned POS_W = 17;
	localparam int unsigned TXN_W = 16;
	localparam int unsigned STAT_W = 3;

	localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;
	localparam logic [POS_W-1:0] HDR_LEN = 17'd6;
	localparam logic [TXN_W-1:0] TXN_LAST = 16'hFFFE;

	localparam logic [POS_W-1:0] POS_TID_HI = 17'd0;
	localparam logic [POS_W-1:0] POS_TID_LO = 17'd1;
	localparam logic [POS_W-1:0] POS_PID_HI = 17'd2;
	localparam logic [POS_W-1:0] POS_PID_LO = 17'd3;
	localparam logic [POS_W-1:0] POS_LEN_HI = 17'd4;
	localparam logic [POS_W-1:0] POS_LEN_LO = 17'd5;
	localparam logic [POS_W-1:0] POS_UNIT = 17'd6;
	localparam logic [POS_W-1:0] POS_FUNC = 17'd7;

	localparam logic REQ_NEW = 1'b0;
	localparam logic REQ_BYTE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_TXN_MISM  = 3'd1,
		ST_PROTO_NZ  = 3'd2,
		ST_BAD_LEN   = 3'd3,
		ST_UNIT_MISM = 3'd4,
		ST_FUNC_MISM = 3'd5
	} status_t;

	typedef struct packed {
		logic [TXN_W-1:0] txn;
		logic [7:0]       func;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] flen;
		logic [7:0]       held;
		logic             pend;
		status_t          err;
	} hdr_state_t;

endpackage

// ----- rtl/mtcp_hdr_next.sv -----
module mtcp_hdr_next (
	input  mtcp_pkg::hdr_state_t cur,
	input  logic                 req_type,
	input  logic [7:0]           function_code,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           slave_address,
	output mtcp_pkg::hdr_state_t nxt,
	output logic                 frame_complete
);

	logic [mtcp_pkg::POS_W-1:0] pos;

	always_comb begin
		nxt = cur;
		pos = cur.pos;
		if (req_type == mtcp_pkg::REQ_NEW) begin
			nxt.txn = (cur.txn >= mtcp_pkg::TXN_LAST) ? '0 : cur.txn + 16'd1;
			nxt.func = function_code;
			nxt.pos = '0;
			nxt.flen = '0;
			nxt.held = '0;
			nxt.pend = 1'b0;
			nxt.err = mtcp_pkg::ST_OK;
		end else if (pos != mtcp_pkg::POS_MAX) begin
			nxt.pos = pos + 17'd1;
			case (pos)
				mtcp_pkg::POS_TID_HI: begin
					nxt.held = rx_byte;
					nxt.pend = (rx_byte != cur.txn[15:8]);
				end
				mtcp_pkg::POS_TID_LO: begin
					if ((cur.pend || rx_byte != cur.txn[7:0]) && cur.err == mtcp_pkg::ST_OK)
						nxt.err = mtcp_pkg::ST_TXN_MISM;
				end
				mtcp_pkg::POS_PID_HI, mtcp_pkg::POS_LEN_HI: begin
					nxt.held = rx_byte;
				end
				mtcp_pkg::POS_PID_LO: begin
					if ((cur.held | rx_byte) != 8'd0 && cur.err == mtcp_pkg::ST_OK)
						nxt.err = mtcp_pkg::ST_PROTO_NZ;
				end
				mtcp_pkg::POS_LEN_LO: begin
					nxt.flen = {1'b0, cur.held, rx_byte} + mtcp_pkg::HDR_LEN;
				end
				default: begin
					if (cur.err == mtcp_pkg::ST_OK) begin
						if (cur.flen == mtcp_pkg::HDR_LEN)
							nxt.err = mtcp_pkg::ST_BAD_LEN;
						else if (pos == mtcp_pkg::POS_UNIT && rx_byte != slave_address)
							nxt.err = mtcp_pkg::ST_UNIT_MISM;
						else if (pos == mtcp_pkg::POS_FUNC && rx_byte != cur.func)
							nxt.err = mtcp_pkg::ST_FUNC_MISM;
					end
				end
			endcase
		end
		frame_complete = (nxt.flen != '0) && (nxt.pos == nxt.flen);
	end

endmodule

// ----- rtl/modbus_tcp_response_header_checker.sv -----
// Channel  Dir  Handshake             Payload
// s        in   s_tvalid / s_tready   tuser: req_type; tdata: function_code, rx_byte
// m        out  m_tvalid / m_tready   tlast: frame_complete; tdata: status, txn, length
// cfg      in   cfg_valid / cfg_ready cfg_data: slave_address
//
// One item per cycle while m is empty or being taken; each result appears in the cycle after its item is accepted.
// The header check is a single pass of compare logic between the state registers
// and the output register, so s_tready is high whenever m is empty or being taken.
// arst_n clears the header state and the output valid; slave_address resets to 255.
// cfg_ready is always high.
module modbus_tcp_response_header_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // [0] req_type
	input  logic [15:0] s_tdata,   // [7:0] function_code, [15:8] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tlast,   // frame_complete
	output logic [39:0] m_tdata,   // [2:0] status, [18:3] transaction_number,
	                               // [35:19] expected_length, [39:36] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	mtcp_pkg::hdr_state_t state_q;
	mtcp_pkg::hdr_state_t state_d;
	logic                 complete_d;
	logic [7:0]           slave_q;
	logic                 s_acc;

	assign cfg_ready = 1'b1;
	assign s_tready = !m_tvalid || m_tready;
	assign s_acc = s_tvalid && s_tready;

	mtcp_hdr_next u_next (
		.cur            (state_q),
		.req_type       (s_tuser),
		.function_code  (s_tdata[7:0]),
		.rx_byte        (s_tdata[15:8]),
		.slave_address  (slave_q),
		.nxt            (state_d),
		.frame_complete (complete_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= 8'hFF;
		end else if (cfg_valid) begin
			slave_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_acc)
				state_q <= state_d;
			if (s_acc)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_tlast <= complete_d;
			m_tdata <= {4'd0, state_d.flen, state_d.txn, state_d.err};
		end
	end

`ifndef SYNTHESIS
	a_new_req_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tuser == mtcp_pkg::REQ_NEW |=>
		m_tvalid && m_tdata[2:0] == mtcp_pkg::ST_OK && m_tdata[35:19] == '0 && !m_tlast)
		else $error("new request result not cleared");
	a_txn_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.txn != 16'hFFFF)
		else $error("transaction counter out of range");
	a_last_has_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[35:19] != '0)
		else $error("frame complete without length");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tuser == mtcp_pkg::REQ_BYTE && state_q.err != mtcp_pkg::ST_OK |=>
		state_q.err == $past(state_q.err))
		else $error("error status changed");
`endif

endmodule

// ----- bench/mbap_check_pkg.sv -----
package mbap_check_pkg;

	import mtcp_pkg::*;

	typedef struct {
		status_t          status;
		logic             done;
		logic [TXN_W-1:0] txn;
		logic [POS_W-1:0] len;
	} mbap_result_t;

	class mbap_scoreboard;
		logic [7:0]       slave;
		logic [TXN_W-1:0] txn;
		logic [7:0]       func;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] flen;
		logic [7:0]       held;
		logic             pend;
		status_t          err;
		mbap_result_t     pending_hdrs[$];
		int               mismatches;

		function new();
			slave = 8'hFF;
			txn = '0;
			func = '0;
			pos = '0;
			flen = '0;
			held = '0;
			pend = 1'b0;
			err = ST_OK;
			mismatches = 0;
		endfunction

		function int pending();
			return pending_hdrs.size();
		endfunction

		function void flag(status_t code);
			if (err == ST_OK) begin
				err = code;
			end
		endfunction

		function void score_byte(logic [POS_W-1:0] at, logic [7:0] b);
			case (at)
				POS_TID_HI: begin
					held = b;
					pend = (b != txn[15:8]);
				end
				POS_TID_LO: begin
					if (pend || b != txn[7:0]) begin
						flag(ST_TXN_MISM);
					end
				end
				POS_PID_HI, POS_LEN_HI: begin
					held = b;
				end
				POS_PID_LO: begin
					if ((held | b) != 8'h00) begin
						flag(ST_PROTO_NZ);
					end
				end
				POS_LEN_LO: begin
					flen = {1'b0, held, b} + HDR_LEN;
				end
				default: begin
					if (flen == HDR_LEN) begin
						flag(ST_BAD_LEN);
					end else if (at == POS_UNIT && b != slave) begin
						flag(ST_UNIT_MISM);
					end else if (at == POS_FUNC && b != func) begin
						flag(ST_FUNC_MISM);
					end
				end
			endcase
		endfunction

		function void advance_header(logic req, logic [7:0] fc, logic [7:0] b);
			logic [POS_W-1:0] at;
			mbap_result_t r;
			if (req == REQ_NEW) begin
				txn = (txn == TXN_LAST) ? '0 : txn + 1'b1;
				func = fc;
				pos = '0;
				flen = '0;
				held = '0;
				pend = 1'b0;
				err = ST_OK;
			end else if (pos != POS_MAX) begin
				at = pos;
				pos = pos + 1'b1;
				score_byte(at, b);
			end
			r.status = err;
			r.done = (flen != '0) && (pos == flen);
			r.txn = txn;
			r.len = flen;
			pending_hdrs.push_back(r);
		endfunction

		function void report(string field, longint unsigned want, longint unsigned got);
			mismatches++;
			if (mismatches <= 100) begin
				$error("%s: expected %0h, got %0h", field, want, got);
			end
		endfunction

		function void compare_response(logic [39:0] d, logic last);
			mbap_result_t w;
			if (pending_hdrs.size() == 0) begin
				mismatches++;
				if (mismatches <= 100) begin
					$error("response with no item pending: tdata %h", d);
				end
				return;
			end
			w = pending_hdrs.pop_front();
			if (d[2:0] !== w.status) begin
				report("status", w.status, d[2:0]);
			end
			if (last !== w.done) begin
				report("frame_complete", w.done, last);
			end
			if (d[18:3] !== w.txn) begin
				report("transaction_number", w.txn, d[18:3]);
			end
			if (d[35:19] !== w.len) begin
				report("expected_length", w.len, d[35:19]);
			end
		endfunction
	endclass

endpackage

// ----- bench/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic        s_tuser = 1'b0;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        m_tlast;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;

	mbap_check_pkg::mbap_scoreboard sb;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          hold_left = 0;
	int          items_sent = 0;
	logic [7:0]  cur_slave = 8'hFF;

	modbus_tcp_response_header_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tlast   (m_tlast),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.advance_header(s_tuser, s_tdata[7:0], s_tdata[15:8]);
			end
			if (m_tvalid && m_tready) begin
				sb.compare_response(m_tdata, m_tlast);
			end
		end
	end

	task automatic send_item(input logic req, input logic [7:0] fc, input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {b, fc};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_response(input logic [15:0] body, input int n_bytes, input int bad_pos,
			input logic [7:0] fc);
		logic [7:0] hdr [8];
		logic [7:0] b;
		hdr[0] = sb.txn[15:8];
		hdr[1] = sb.txn[7:0];
		hdr[2] = 8'h00;
		hdr[3] = 8'h00;
		hdr[4] = body[15:8];
		hdr[5] = body[7:0];
		hdr[6] = cur_slave;
		hdr[7] = fc;
		for (int i = 0; i < n_bytes; i++) begin
			b = (i < 8) ? hdr[i] : 8'($urandom_range(255));
			if (i == bad_pos) begin
				b ^= 8'($urandom_range(1, 255));
			end
			send_item(mtcp_pkg::REQ_BYTE, 8'($urandom_range(255)), b);
		end
	endtask

	task automatic write_slave(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.slave = v;
		cur_slave = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic directed_items();
		logic [7:0] pre [8];
		pre = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00};
		// bytes ahead of any request see counter 0 and function 0
		foreach (pre[i]) begin
			send_item(mtcp_pkg::REQ_BYTE, 8'hA5, pre[i]);
		end
		// zero body length, then one byte past the header
		send_item(mtcp_pkg::REQ_NEW, 8'hFF, 8'h00);
		send_response(16'h0000, 7, -1, 8'hFF);
		// wrong transaction id, then later errors stay hidden
		send_item(mtcp_pkg::REQ_NEW, 8'h80, 8'hFF);
		repeat (6) send_item(mtcp_pkg::REQ_BYTE, 8'h00, 8'hFF);
		send_item(mtcp_pkg::REQ_NEW, 8'h00, 8'hFF);
		send_item(mtcp_pkg::REQ_BYTE, 8'hFF, 8'h00);
	endtask

	task automatic random_traffic(input int budget);
		int stop;
		int r;
		int n;
		int bad;
		logic [7:0] fc;
		logic [15:0] body;
		stop = items_sent + budget;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			if (r < 78) begin
				fc = 8'($urandom_range(255));
				if ($urandom_range(9) != 0) begin
					send_item(mtcp_pkg::REQ_NEW, fc, 8'($urandom_range(255)));
				end
				r = $urandom_range(99);
				if (r < 10) begin
					body = 16'h0000;
				end else if (r < 80) begin
					body = 16'($urandom_range(1, 10));
				end else if (r < 90) begin
					body = 16'($urandom_range(11, 40));
				end else begin
					body = 16'($urandom_range(16'hFFFF));
				end
				n = 6 + ((body > 40) ? 40 : int'(body));
				r = $urandom_range(9);
				if (r == 0) begin
					n = $urandom_range(0, n);
				end else if (r == 1) begin
					n += $urandom_range(1, 4);
				end
				bad = ($urandom_range(3) == 0) ? int'($urandom_range(7)) : -1;
				send_response(body, n, bad, fc);
			end else begin
				n = $urandom_range(1, 12);
				repeat (n) begin
					send_item(($urandom_range(4) == 0) ? mtcp_pkg::REQ_NEW : mtcp_pkg::REQ_BYTE,
						8'($urandom_range(255)), 8'($urandom_range(255)));
				end
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 31;
		rx_idle_pct = 52;
		directed_items();
		drain();
		write_slave(8'h00);
		random_traffic(200);
		hold_left = 400;
		random_traffic(200);
		drain();

		tx_idle_pct = 52;
		rx_idle_pct = 31;
		write_slave(8'hFF);
		random_traffic(400);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_slave(8'($urandom_range(1, 254)));
		random_traffic(350);

		drain();
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[modbus_tcp_response_header_checker] OK");
		end else begin
			$display("[modbus_tcp_response_header_checker] ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[modbus_tcp_response_header_checker] ERROR");
		$finish;
	end

endmodule
